// ----- hdl/remote_id_advert_decoder_unit_defines.svh -----
// Assertion macros used by the checker of this block.
`ifndef REMOTE_ID_ADVERT_DECODER_UNIT_DEFINES_SVH
`define REMOTE_ID_ADVERT_DECODER_UNIT_DEFINES_SVH

// same-cycle implication
`define RIDAD_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("remote id decoder check failed");

// next-cycle implication
`define RIDAD_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("remote id decoder check failed");

`endif

// ----- hdl/ridad_pkg.sv -----
package ridad_pkg;

   localparam int MESSAGE_BYTES = 25;
   localparam int SERIAL_BYTES  = 20;
   localparam int CHUNK_COUNT   = 3;

   localparam logic [7:0] AD_TYPE_SERVICE_DATA = 8'h16;
   localparam logic [7:0] UUID_LOW_BYTE        = 8'hFA;
   localparam logic [7:0] UUID_HIGH_BYTE       = 8'hFF;
   localparam logic [7:0] APP_CODE_REMOTE_ID   = 8'h0D;
   localparam logic [7:0] SERIAL_PAD_SPACE     = 8'h20;
   localparam logic [7:0] MIN_STRUCT_LENGTH    = 8'h04;

   localparam logic [3:0][7:0] HEADER_BYTES = {APP_CODE_REMOTE_ID, UUID_HIGH_BYTE,
                                               UUID_LOW_BYTE, AD_TYPE_SERVICE_DATA};

   localparam logic [3:0] KIND_BASIC_ID = 4'h0;
   localparam logic [3:0] KIND_LOCATION = 4'h1;
   localparam logic [3:0] KIND_SYSTEM   = 4'h4;

   localparam logic [16:0] ALTITUDE_OFFSET = 17'd2000;

   typedef enum logic [1:0] {
      MATCH_NONE,
      MATCH_HEADER,
      MATCH_CAPTURE
   } match_type;

   typedef logic [MESSAGE_BYTES-1:0][7:0] message_type;

   typedef struct packed {
      logic [7:0]  advert_byte;
      logic        final_byte;
      logic [31:0] stamp;
   } req_type;

   typedef struct packed {
      logic               accepted;
      logic [3:0]         aircraft_type;
      logic signed [31:0] vehicle_lat;
      logic signed [31:0] vehicle_lon;
      logic signed [16:0] altitude_half_m;
      logic signed [31:0] pilot_lat;
      logic signed [31:0] pilot_lon;
      logic [2:0]         have_marks;
      logic [31:0]        update_time;
      logic [63:0]        serial_chunk;
      logic [1:0]         chunk_index;
      logic               run_end;
   } rsp_type;

endpackage

// ----- hdl/ridad_parse.sv -----
module ridad_parse (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  logic [7:0]            advert_byte,
   input  logic                  final_byte,
   output ridad_pkg::message_type msg_view,
   output logic                  merge_ok
);
   import ridad_pkg::*;

   logic [7:0] pos_ff, pos_in;
   logic [8:0] nss_ff, nss_in;
   logic [7:0] slen_ff, slen_in;
   logic       stopped_ff, stopped_in;
   match_type  match_ff, match_in;
   logic [7:0] msg_ff [MESSAGE_BYTES];

   logic       active;
   logic [9:0] rel;
   logic [9:0] rel_cap;
   logic [9:0] rel_hdr;
   logic [4:0] cap_idx;
   logic       cap_we;
   logic [7:0] len_after;

   always_comb begin
      active     = (pos_ff != 8'd255);
      rel        = {2'b00, pos_ff} + 10'd1 + {2'b00, slen_ff} - {1'b0, nss_ff};
      rel_cap    = rel - 10'd6;
      rel_hdr    = rel - 10'd1;
      cap_idx    = rel_cap[4:0];
      pos_in     = pos_ff;
      nss_in     = nss_ff;
      slen_in    = slen_ff;
      stopped_in = stopped_ff;
      match_in   = match_ff;
      cap_we     = 1'b0;
      if (active) begin
         pos_in = pos_ff + 8'd1;
         if (!stopped_ff && ({1'b0, pos_ff} == nss_ff)) begin
            if (advert_byte == 8'd0) begin
               stopped_in = 1'b1;
               match_in   = MATCH_NONE;
            end else begin
               slen_in  = advert_byte;
               nss_in   = {1'b0, pos_ff} + 9'd1 + {1'b0, advert_byte};
               match_in = (advert_byte >= MIN_STRUCT_LENGTH) ? MATCH_HEADER : MATCH_NONE;
            end
         end else if (match_ff == MATCH_HEADER && rel >= 10'd1 && rel <= 10'd4) begin
            if (advert_byte != HEADER_BYTES[rel_hdr[1:0]]) begin
               match_in = MATCH_NONE;
            end else if (rel == 10'd4) begin
               stopped_in = 1'b1;
               match_in   = (slen_ff >= 8'(MESSAGE_BYTES + 5)) ? MATCH_CAPTURE : MATCH_NONE;
            end
         end else if (match_ff == MATCH_CAPTURE && rel >= 10'd6
                      && rel <= 10'(MESSAGE_BYTES + 5)) begin
            cap_we = 1'b1;
         end
      end
      len_after = pos_in;
      merge_ok  = (len_after >= 8'd4) && (match_in == MATCH_CAPTURE)
                  && (nss_in <= {1'b0, len_after});
      for (int i = 0; i < MESSAGE_BYTES; i++) begin
         msg_view[i] = (cap_we && cap_idx == 5'(i)) ? advert_byte : msg_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         nss_ff     <= '0;
         slen_ff    <= '0;
         stopped_ff <= 1'b0;
         match_ff   <= MATCH_NONE;
      end else if (take) begin
         if (final_byte) begin
            pos_ff     <= '0;
            nss_ff     <= '0;
            slen_ff    <= '0;
            stopped_ff <= 1'b0;
            match_ff   <= MATCH_NONE;
         end else begin
            pos_ff     <= pos_in;
            nss_ff     <= nss_in;
            slen_ff    <= slen_in;
            stopped_ff <= stopped_in;
            match_ff   <= match_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && cap_we) begin
         msg_ff[cap_idx] <= advert_byte;
      end
   end

endmodule

// ----- hdl/remote_id_advert_decoder_unit.sv -----
// Remote ID legacy advert decoder: takes one advert byte per cycle while no
// result run is busy, walks the length-type-data structures and captures the
// 25-byte Remote ID message. A byte marked final merges the message into the
// vehicle record and starts a run of three result items (record plus one
// 64-bit serial chunk each). The serial lives in a three-word chunk memory
// read one word per cycle; byte intake pauses from the final byte until the
// run's last item enters the output register, and the run advances only while
// the output register is empty or its item is taken.
module remote_id_advert_decoder_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ridad_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ridad_pkg::rsp_type rsp_item
);
   import ridad_pkg::*;

   logic        take;
   logic        take_final;
   message_type msg_view;
   logic        merge_ok;
   logic [3:0]  kind;
   logic [31:0] loc_lat, loc_lon, sys_lat, sys_lon;
   logic [16:0] alt_raw;

   logic [3:0]  atype_ff, atype_in;
   logic [31:0] vlat_ff, vlat_in, vlon_ff, vlon_in;
   logic [16:0] alt_ff, alt_in;
   logic [31:0] plat_ff, plat_in, plon_ff, plon_in;
   logic [2:0]  have_ff, have_in;
   logic [31:0] upd_ff, upd_in;
   logic        ok_ff, ok_in;
   logic        newser_ff, newser_in;
   logic [CHUNK_COUNT-1:0][63:0] snap_ff, snap_in;

   logic [SERIAL_BYTES-1:0]      nonblank, keep;
   logic [SERIAL_BYTES-1:0][7:0] serial;

   logic        run_ff, run_in;
   logic [1:0]  k_ff, k_in;
   logic        advance, last;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_ff, out_in;

   logic [63:0] ser_mem [CHUNK_COUNT];
   logic [CHUNK_COUNT-1:0] ser_vld_ff;
   logic [63:0] rd_data_ff;
   logic        rd_vld_ff;
   logic [63:0] chunk;

   ridad_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .advert_byte (req_item.advert_byte),
      .final_byte  (req_item.final_byte),
      .msg_view    (msg_view),
      .merge_ok    (merge_ok)
   );

   assign take       = req_valid && req_ready;
   assign take_final = take && req_item.final_byte;

   always_comb begin
      kind    = msg_view[0][7:4];
      loc_lat = {msg_view[8], msg_view[7], msg_view[6], msg_view[5]};
      loc_lon = {msg_view[12], msg_view[11], msg_view[10], msg_view[9]};
      sys_lat = {msg_view[5], msg_view[4], msg_view[3], msg_view[2]};
      sys_lon = {msg_view[9], msg_view[8], msg_view[7], msg_view[6]};
      alt_raw = {1'b0, msg_view[16], msg_view[15]};

      for (int i = 0; i < SERIAL_BYTES; i++) begin
         nonblank[i] = (msg_view[i+2] != SERIAL_PAD_SPACE) && (msg_view[i+2] != 8'd0);
      end
      for (int i = 0; i < SERIAL_BYTES; i++) begin
         keep[i] = 1'b0;
         for (int j = 0; j < SERIAL_BYTES; j++) begin
            if (j >= i) begin
               keep[i] = keep[i] | nonblank[j];
            end
         end
         serial[i] = keep[i] ? msg_view[i+2] : 8'd0;
      end
      for (int c = 0; c < CHUNK_COUNT; c++) begin
         for (int j = 0; j < 8; j++) begin
            if (c * 8 + j < SERIAL_BYTES) begin
               snap_in[c][j*8 +: 8] = serial[c*8 + j];
            end else begin
               snap_in[c][j*8 +: 8] = 8'd0;
            end
         end
      end

      atype_in  = atype_ff;
      vlat_in   = vlat_ff;
      vlon_in   = vlon_ff;
      alt_in    = alt_ff;
      plat_in   = plat_ff;
      plon_in   = plon_ff;
      have_in   = have_ff;
      upd_in    = upd_ff;
      ok_in     = ok_ff;
      newser_in = newser_ff;
      if (take_final) begin
         ok_in     = 1'b0;
         newser_in = 1'b0;
         if (merge_ok) begin
            case (kind)
               KIND_BASIC_ID: begin
                  atype_in  = msg_view[1][3:0];
                  have_in   = have_ff | 3'b001;
                  upd_in    = req_item.stamp;
                  ok_in     = 1'b1;
                  newser_in = 1'b1;
               end
               KIND_LOCATION: begin
                  ok_in = 1'b1;
                  if (loc_lat != 32'd0 || loc_lon != 32'd0) begin
                     vlat_in = loc_lat;
                     vlon_in = loc_lon;
                     alt_in  = alt_raw - ALTITUDE_OFFSET;
                     have_in = have_ff | 3'b010;
                     upd_in  = req_item.stamp;
                  end
               end
               KIND_SYSTEM: begin
                  ok_in = 1'b1;
                  if (sys_lat != 32'd0 || sys_lon != 32'd0) begin
                     plat_in = sys_lat;
                     plon_in = sys_lon;
                     have_in = have_ff | 3'b100;
                     upd_in  = req_item.stamp;
                  end
               end
               default: begin
                  ok_in = 1'b0;
               end
            endcase
         end
      end
   end

   always_comb begin
      advance   = run_ff && (!out_valid_ff || rsp_ready);
      last      = advance && (k_ff == 2'(CHUNK_COUNT - 1));
      req_ready = !run_ff || last;
      run_in    = take_final ? 1'b1 : (last ? 1'b0 : run_ff);
      k_in      = advance ? (last ? 2'd0 : k_ff + 2'd1) : k_ff;
      out_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

      chunk = newser_ff ? snap_ff[k_ff] : (rd_vld_ff ? rd_data_ff : 64'd0);
      out_in                 = out_ff;
      if (advance) begin
         out_in.accepted        = ok_ff;
         out_in.aircraft_type   = atype_ff;
         out_in.vehicle_lat     = vlat_ff;
         out_in.vehicle_lon     = vlon_ff;
         out_in.altitude_half_m = alt_ff;
         out_in.pilot_lat       = plat_ff;
         out_in.pilot_lon       = plon_ff;
         out_in.have_marks      = have_ff;
         out_in.update_time     = upd_ff;
         out_in.serial_chunk    = chunk;
         out_in.chunk_index     = k_ff;
         out_in.run_end         = (k_ff == 2'(CHUNK_COUNT - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         atype_ff     <= '0;
         vlat_ff      <= '0;
         vlon_ff      <= '0;
         alt_ff       <= '0;
         plat_ff      <= '0;
         plon_ff      <= '0;
         have_ff      <= '0;
         upd_ff       <= '0;
         ok_ff        <= 1'b0;
         newser_ff    <= 1'b0;
         run_ff       <= 1'b0;
         k_ff         <= '0;
         out_valid_ff <= 1'b0;
         ser_vld_ff   <= '0;
         rd_vld_ff    <= 1'b0;
      end else begin
         atype_ff     <= atype_in;
         vlat_ff      <= vlat_in;
         vlon_ff      <= vlon_in;
         alt_ff       <= alt_in;
         plat_ff      <= plat_in;
         plon_ff      <= plon_in;
         have_ff      <= have_in;
         upd_ff       <= upd_in;
         ok_ff        <= ok_in;
         newser_ff    <= newser_in;
         run_ff       <= run_in;
         k_ff         <= k_in;
         out_valid_ff <= out_valid_in;
         if (advance && newser_ff) begin
            ser_vld_ff[k_ff] <= 1'b1;
         end
         rd_vld_ff <= ser_vld_ff[k_in];
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (take_final) begin
         snap_ff <= snap_in;
      end
   end

   // chunk memory: write the new serial during its run, read one word ahead
   always_ff @(posedge clock) begin
      if (advance && newser_ff) begin
         ser_mem[k_ff] <= snap_ff[k_ff];
      end
      rd_data_ff <= ser_mem[k_in];
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;

endmodule

// ----- hdl/ridad_checker.sv -----
`include "remote_id_advert_decoder_unit_defines.svh"

module ridad_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input ridad_pkg::req_type req_item,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input ridad_pkg::rsp_type rsp_item
);
   import ridad_pkg::*;

   `RIDAD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_item))
   `RIDAD_ASSERT_IMPL(a_run_end_last, rsp_valid && rsp_item.run_end, rsp_item.chunk_index == 2'(CHUNK_COUNT - 1))
   `RIDAD_ASSERT_NEXT(a_run_continues, rsp_valid && rsp_ready && !rsp_item.run_end, rsp_valid)
   `RIDAD_ASSERT_NEXT(a_final_pauses, req_valid && req_ready && req_item.final_byte, !req_ready)

endmodule

bind remote_id_advert_decoder_unit ridad_checker u_ridad_checker (.*);

// ----- dv/remote_id_advert_decoder_unit_checker.sv -----
module remote_id_advert_decoder_unit_checker
   import ridad_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_item,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_item,
   output int      fail_count,
   output int      pending_count,
   output int      record_count
);
   timeunit 1ns;
   timeprecision 1ps;

   int unsigned      byte_pos;
   int unsigned      struct_end;
   int unsigned      struct_len;
   logic             walk_done;
   match_type        match_state;
   logic [7:0]       msg [MESSAGE_BYTES];
   logic [7:0]       serial [SERIAL_BYTES];
   logic [3:0]       ua_type;
   logic [31:0]      veh_lat, veh_lon, op_lat, op_lon;
   logic [16:0]      alt;
   logic [2:0]       marks;
   logic [31:0]      last_stamp;
   rsp_type          expected_q[$];

   assign pending_count = expected_q.size();

   function automatic logic [31:0] msg_word(int at);
      return {msg[at+3], msg[at+2], msg[at+1], msg[at]};
   endfunction

   function automatic logic merge_message(logic [31:0] now);
      logic [3:0]  kind;
      logic [31:0] la, lo;
      kind = msg[0][7:4];
      if (kind == KIND_BASIC_ID) begin
         ua_type = msg[1][3:0];
         for (int i = 0; i < SERIAL_BYTES; i++) serial[i] = msg[i+2];
         for (int i = SERIAL_BYTES - 1; i >= 0; i--) begin
            if (serial[i] == SERIAL_PAD_SPACE || serial[i] == 8'h00) serial[i] = 8'h00;
            else break;
         end
         marks |= 3'b001;
         last_stamp = now;
         return 1'b1;
      end
      if (kind == KIND_LOCATION) begin
         la = msg_word(5);
         lo = msg_word(9);
         if (la == 0 && lo == 0) return 1'b1;
         veh_lat = la;
         veh_lon = lo;
         alt = {1'b0, msg[16], msg[15]} - ALTITUDE_OFFSET;
         marks |= 3'b010;
         last_stamp = now;
         return 1'b1;
      end
      if (kind == KIND_SYSTEM) begin
         la = msg_word(2);
         lo = msg_word(6);
         if (la == 0 && lo == 0) return 1'b1;
         op_lat = la;
         op_lon = lo;
         marks |= 3'b100;
         last_stamp = now;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic walk_byte(logic [7:0] b);
      int unsigned rel;
      rel = byte_pos + 1 + struct_len - struct_end;
      if (!walk_done && byte_pos == struct_end) begin
         if (b == 0) begin
            walk_done = 1'b1;
            match_state = MATCH_NONE;
         end else begin
            struct_len = b;
            struct_end = byte_pos + 1 + b;
            match_state = (b >= MIN_STRUCT_LENGTH) ? MATCH_HEADER : MATCH_NONE;
         end
      end else if (match_state == MATCH_HEADER && rel >= 1 && rel <= 4) begin
         if (b != HEADER_BYTES[rel-1]) begin
            match_state = MATCH_NONE;
         end else if (rel == 4) begin
            walk_done = 1'b1;
            match_state = (struct_len >= 4 + MESSAGE_BYTES + 1) ? MATCH_CAPTURE : MATCH_NONE;
         end
      end else if (match_state == MATCH_CAPTURE && rel >= 6 && rel < 6 + MESSAGE_BYTES) begin
         msg[rel-6] = b;
      end
   endtask

   task automatic predict_item(req_type it);
      logic    ok;
      rsp_type r;
      if (byte_pos < 255) begin
         walk_byte(it.advert_byte);
         byte_pos++;
      end
      if (!it.final_byte) return;
      ok = 1'b0;
      if (byte_pos >= 4 && match_state == MATCH_CAPTURE && struct_end <= byte_pos)
         ok = merge_message(it.stamp);
      for (int k = 0; k < CHUNK_COUNT; k++) begin
         r = '0;
         r.accepted = ok;
         r.aircraft_type = ua_type;
         r.vehicle_lat = veh_lat;
         r.vehicle_lon = veh_lon;
         r.altitude_half_m = alt;
         r.pilot_lat = op_lat;
         r.pilot_lon = op_lon;
         r.have_marks = marks;
         r.update_time = last_stamp;
         for (int j = 0; j < 8; j++)
            if (k * 8 + j < SERIAL_BYTES) r.serial_chunk[8*j +: 8] = serial[k*8+j];
         r.chunk_index = k[1:0];
         r.run_end = (k == CHUNK_COUNT - 1);
         expected_q.push_back(r);
      end
      record_count++;
      byte_pos = 0;
      struct_end = 0;
      struct_len = 0;
      walk_done = 1'b0;
      match_state = MATCH_NONE;
   endtask

   task automatic compare_result(rsp_type got);
      rsp_type e;
      if (expected_q.size() == 0) begin
         $display("%0t: unexpected result %h", $time, got);
         fail_count++;
         return;
      end
      e = expected_q.pop_front();
      if (got.accepted !== e.accepted || got.aircraft_type !== e.aircraft_type ||
          got.vehicle_lat !== e.vehicle_lat || got.vehicle_lon !== e.vehicle_lon ||
          got.altitude_half_m !== e.altitude_half_m || got.pilot_lat !== e.pilot_lat ||
          got.pilot_lon !== e.pilot_lon || got.have_marks !== e.have_marks ||
          got.update_time !== e.update_time || got.serial_chunk !== e.serial_chunk ||
          got.chunk_index !== e.chunk_index || got.run_end !== e.run_end) begin
         $display("%0t: mismatch expected %h actual %h", $time, e, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         byte_pos = 0;
         struct_end = 0;
         struct_len = 0;
         walk_done = 1'b0;
         match_state = MATCH_NONE;
         for (int i = 0; i < MESSAGE_BYTES; i++) msg[i] = 8'h00;
         for (int i = 0; i < SERIAL_BYTES; i++) serial[i] = 8'h00;
         ua_type = '0;
         veh_lat = '0;
         veh_lon = '0;
         op_lat = '0;
         op_lon = '0;
         alt = '0;
         marks = '0;
         last_stamp = '0;
         expected_q.delete();
         fail_count = 0;
         record_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) compare_result(rsp_item);
         if (req_valid && req_ready) predict_item(req_item);
      end
   end
endmodule

// ----- dv/remote_id_advert_decoder_unit_tb.sv -----
module remote_id_advert_decoder_unit_tb;
   import ridad_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_item;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_item;
   int      fail_count;
   int      pending_count;
   int      record_count;
   int      byte_count;
   bit      stall_off;

   logic [7:0] advert [$];

   remote_id_advert_decoder_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_item(rsp_item)
   );

   remote_id_advert_decoder_unit_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_item(rsp_item),
      .fail_count(fail_count), .pending_count(pending_count),
      .record_count(record_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("timeout");
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int phase;
      rsp_ready = 1'b0;
      phase = 0;
      forever begin
         @(negedge clock);
         phase++;
         if (stall_off) rsp_ready <= 1'b1;
         else if (phase % 64 < 16) rsp_ready <= 1'b1;
         else rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   int burst_left;

   task automatic send_byte(logic [7:0] b, logic fin);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 4);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_item.advert_byte <= b;
      req_item.final_byte <= fin;
      req_item.stamp <= $urandom;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      byte_count++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      wait (pending_count == 0);
      @(negedge clock);
   endtask

   task automatic send_advert();
      for (int i = 0; i < advert.size(); i++)
         send_byte(advert[i], i == advert.size() - 1);
   endtask

   task automatic build_remote_id(logic [3:0] kind, bit zero_pos, int struct_len);
      logic [7:0] m [MESSAGE_BYTES];
      for (int i = 0; i < MESSAGE_BYTES; i++) m[i] = 8'($urandom);
      m[0][7:4] = kind;
      if (kind == KIND_BASIC_ID && $urandom_range(0, 1)) begin
         for (int i = $urandom_range(2, 21); i < 22; i++)
            m[i] = $urandom_range(0, 1) ? SERIAL_PAD_SPACE : 8'h00;
      end
      if (zero_pos) begin
         if (kind == KIND_LOCATION) for (int i = 5; i < 13; i++) m[i] = 8'h00;
         else for (int i = 2; i < 10; i++) m[i] = 8'h00;
      end
      advert.push_back(struct_len[7:0]);
      advert.push_back(AD_TYPE_SERVICE_DATA);
      advert.push_back(UUID_LOW_BYTE);
      advert.push_back(UUID_HIGH_BYTE);
      advert.push_back(APP_CODE_REMOTE_ID);
      advert.push_back(8'($urandom));
      for (int i = 0; i < MESSAGE_BYTES; i++) advert.push_back(m[i]);
      for (int i = 30; i < struct_len; i++) advert.push_back(8'($urandom));
   endtask

   function automatic logic [3:0] pick_kind();
      case ($urandom_range(0, 6))
         0, 1:    return KIND_BASIC_ID;
         2, 3:    return KIND_LOCATION;
         4, 5:    return KIND_SYSTEM;
         default: return 4'($urandom);
      endcase
   endfunction

   task automatic random_advert();
      int mode;
      int n;
      advert.delete();
      mode = $urandom_range(0, 9);
      if (mode < 6) begin
         if ($urandom_range(0, 2) == 0) begin
            n = $urandom_range(1, 4);
            advert.push_back(n[7:0]);
            for (int i = 0; i < n; i++) advert.push_back(8'($urandom));
         end
         build_remote_id(pick_kind(), $urandom_range(0, 7) == 0,
                         $urandom_range(0, 3) == 0 ? $urandom_range(30, 34) : 30);
         if ($urandom_range(0, 1)) advert.push_back(8'h00);
      end else if (mode == 6) begin
         build_remote_id(pick_kind(), 1'b0, 30);
         repeat ($urandom_range(1, 8)) void'(advert.pop_back());
      end else if (mode == 7) begin
         n = $urandom_range(1, 3);
         for (int i = 0; i < n; i++) advert.push_back(8'($urandom));
      end else if (mode == 8) begin
         advert.push_back(8'($urandom_range(4, 29)));
         advert.push_back(AD_TYPE_SERVICE_DATA);
         advert.push_back(UUID_LOW_BYTE);
         advert.push_back(UUID_HIGH_BYTE);
         advert.push_back(APP_CODE_REMOTE_ID);
         repeat ($urandom_range(0, 30)) advert.push_back(8'($urandom));
      end else begin
         n = $urandom_range(4, 12);
         for (int i = 0; i < n; i++) advert.push_back(8'($urandom));
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      stall_off = 1'b0;
      byte_count = 0;
      burst_left = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      advert = {8'h00, 8'h00};
      send_advert();
      advert = {8'hFF, 8'hFF, 8'h00};
      send_advert();
      advert.delete();
      build_remote_id(KIND_BASIC_ID, 1'b0, 30);
      send_advert();
      advert.delete();
      build_remote_id(KIND_LOCATION, 1'b1, 30);
      send_advert();
      advert.delete();
      build_remote_id(KIND_SYSTEM, 1'b0, 31);
      send_advert();
      advert.delete();
      build_remote_id(4'hF, 1'b0, 30);
      send_advert();
      drain();

      while (byte_count < 195) begin
         random_advert();
         send_advert();
         if ($urandom_range(0, 15) == 0) drain();
      end
      advert = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
      send_advert();
      advert = {8'h00, 8'h00, 8'h00, 8'h00};
      send_advert();

      stall_off = 1'b1;
      drain();
      repeat (20) @(posedge clock);
      $display("Sent %0d advert bytes making %0d records", byte_count, record_count);
      $display("Adverts covered Basic ID, Location, System, short, overrun and cut-off cases");
      if (fail_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule

// ----- remote_id_advert_decoder_unit.f -----
+incdir+hdl
hdl/ridad_pkg.sv
hdl/ridad_parse.sv
hdl/remote_id_advert_decoder_unit.sv
hdl/ridad_checker.sv
dv/remote_id_advert_decoder_unit_checker.sv
dv/remote_id_advert_decoder_unit_tb.sv
